### hw/rtl/binom_pkg.sv
// Package with widths, status codes, payload types and sequencer states for the binomial block.
`default_nettype none

package binom_pkg;

   localparam int ARG_BITS    = 8;
   localparam int RESULT_BITS = 31;
   localparam int STATUS_BITS = 2;

   // Width of the running value times one factor, which is the dividend of each step.
   localparam int PROD_BITS = RESULT_BITS + ARG_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NEG_ARG  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [ARG_BITS-1:0] n_value;
      logic signed [ARG_BITS-1:0] k_value;
   } req_payload_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] coefficient;
      logic [STATUS_BITS-1:0] status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_CHECK,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/binomial_coefficient.sv
// Top level of the binomial coefficient block: sequencer, shared multiplier and radix-2 divider.
`default_nettype none

// Computes C(n,k) for n and k taken as two's complement, one transfer in and one transfer out per
// item, one item at a time. The value is built as C(n-m+i, i) for i = 1 .. m with
// m = min(k, n-k): each step runs the multiplier, then a restoring radix-2 divide by i that
// retires one quotient bit per cycle over the whole product width, then a range check. A
// negative argument, k above n, k equal to 0 or n goes straight from idle to the output stage.
// The input is accepted again as soon as the result sits in the output register, so a stalled
// result does not hold up the next item's start, only its delivery.
module binomial_coefficient
   import binom_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   state_type state_ff, state_in;

   logic [RESULT_BITS-1:0] c_ff, c_in;
   logic [ARG_BITS-1:0]    base_ff, base_in;
   logic [ARG_BITS-1:0]    m_ff, m_in;
   logic [ARG_BITS-1:0]    i_ff, i_in;
   logic [PROD_BITS-1:0]   quot_ff, quot_in;
   logic [ARG_BITS-1:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [RESULT_BITS-1:0] res_coef_ff, res_coef_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic [ARG_BITS-1:0]  n_u, k_u, diff_u, m_new;
   logic                 arg_neg;
   logic [ARG_BITS-1:0]  factor;
   logic [PROD_BITS-1:0] mul_prod;
   logic [ARG_BITS:0]    trial;
   logic                 trial_ge;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign n_u     = req_data.n_value;
   assign k_u     = req_data.k_value;
   assign arg_neg = req_data.n_value[ARG_BITS-1] || req_data.k_value[ARG_BITS-1];
   assign diff_u  = n_u - k_u;
   assign m_new   = (k_u < diff_u) ? k_u : diff_u;

   // Shared arithmetic: one narrow multiply per step, one divider bit per cycle.
   assign factor   = base_ff + i_ff;
   assign mul_prod = PROD_BITS'(c_ff) * PROD_BITS'(factor);
   assign trial    = {rem_ff, quot_ff[PROD_BITS-1]};
   assign trial_ge = (trial >= {1'b0, i_ff});

   always_comb begin
      state_in      = state_ff;
      c_in          = c_ff;
      base_in       = base_ff;
      m_in          = m_ff;
      i_in          = i_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_coef_in   = res_coef_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               base_in = n_u - m_new;
               m_in    = m_new;
               c_in    = RESULT_BITS'(1);
               i_in    = ARG_BITS'(1);
               if (arg_neg) begin
                  res_coef_in   = '0;
                  res_status_in = STATUS_NEG_ARG;
                  state_in      = ST_OUT;
               end else if (k_u > n_u) begin
                  res_coef_in   = '0;
                  res_status_in = STATUS_OK;
                  state_in      = ST_OUT;
               end else if (m_new == '0) begin
                  res_coef_in   = RESULT_BITS'(1);
                  res_status_in = STATUS_OK;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            quot_in  = mul_prod;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division; the quotient replaces the dividend bit by bit.
            if (trial_ge) begin
               rem_in = ARG_BITS'(trial - {1'b0, i_ff});
            end else begin
               rem_in = ARG_BITS'(trial);
            end
            quot_in = {quot_ff[PROD_BITS-2:0], trial_ge};
            cnt_in  = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(PROD_BITS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The running value never decreases, so leaving the range once means overflow.
            if (quot_ff[PROD_BITS-1:RESULT_BITS] != '0) begin
               res_coef_in   = '0;
               res_status_in = STATUS_OVERFLOW;
               state_in      = ST_OUT;
            end else if (i_ff == m_ff) begin
               res_coef_in   = quot_ff[RESULT_BITS-1:0];
               res_status_in = STATUS_OK;
               state_in      = ST_OUT;
            end else begin
               c_in     = quot_ff[RESULT_BITS-1:0];
               i_in     = i_ff + ARG_BITS'(1);
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.coefficient = res_coef_ff;
               rsp_data_in.status      = res_status_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff          <= c_in;
      base_ff       <= base_in;
      m_ff          <= m_in;
      i_ff          <= i_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      res_coef_ff   <= res_coef_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // An error status always carries a zero coefficient.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> (rsp_data.coefficient == '0))
      else $error("error status with nonzero coefficient");

   // The divider never runs with a zero divisor, and its remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (i_ff != '0) && (rem_ff < i_ff))
      else $error("divider remainder out of range");

   // A negative argument goes straight to the output stage.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && arg_neg |=> (state_ff == ST_OUT) && (res_status_ff == STATUS_NEG_ARG))
      else $error("negative argument not reported at once");

   // The step counter never passes the number of steps of the item.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (i_ff <= m_ff) && (i_ff != '0))
      else $error("step index out of range");

endmodule

`default_nettype wire
